// ===== hdl/smcb_pkg.sv =====
// ----------------------------------------------------------------------------
// smcb_pkg
// Shared constants for the sensor min/max calibration and binarization block.
// ----------------------------------------------------------------------------
package smcb_pkg;

  // Default configuration of the block
  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths on the item and result channels
  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 10;
  localparam int THR_W     = 10;
  localparam int SPREAD_W  = 10;

  // Register port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPREAD  = 2'd1;

  localparam logic                CALIBRATING_RST = 1'b1;
  localparam logic [SPREAD_W-1:0] MIN_SPREAD_RST  = 10'd200;

endpackage

// ===== hdl/smcb_if.sv =====
// ----------------------------------------------------------------------------
// smcb channel interfaces
// Valid/ready channels for sample items, result items and register writes.
// ----------------------------------------------------------------------------

interface smcb_item_if;
  logic                           valid;
  logic                           ready;
  logic [smcb_pkg::CHANNEL_W-1:0] channel;
  logic [smcb_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface smcb_result_if;
  logic                       valid;
  logic                       ready;
  logic                       line_bit;
  logic [smcb_pkg::THR_W-1:0] threshold_now;
  logic                       all_calibrated;

  modport source (output valid, output line_bit, output threshold_now,
                  output all_calibrated, input ready);
  modport sink   (input valid, input line_bit, input threshold_now,
                  input all_calibrated, output ready);
endinterface

interface smcb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [smcb_pkg::CFG_IDX_W-1:0]  index;
  logic [smcb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/smcb_state_mem.sv =====
// ----------------------------------------------------------------------------
// smcb_state_mem
// Per-channel state memory with registered read, valid bits and write forwarding.
// ----------------------------------------------------------------------------
module smcb_state_mem #(
  parameter int             DEPTH      = smcb_pkg::CHANNELS_DEF,
  parameter int             AW         = 3,
  parameter int             W          = 30,
  parameter logic [W-1:0]   RESET_WORD = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i
);

  logic [W-1:0]     mem [DEPTH];
  logic [W-1:0]     rd_raw_q;
  logic [W-1:0]     fwd_data_q;
  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;
  logic             fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q   <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Valid bits stand in for the reset value of every entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // A write to the same entry on the read edge wins over the stale array data
  assign rd_data_o = fwd_hit_q ? fwd_data_q :
                     rd_vld_q  ? rd_raw_q   : RESET_WORD;

endmodule

// ===== hdl/smcb_update.sv =====
// ----------------------------------------------------------------------------
// smcb_update
// Extreme tracking, spread check, midpoint threshold and binarization.
// ----------------------------------------------------------------------------
module smcb_update #(
  parameter int SB = smcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          calibrating_i,
  input  logic [smcb_pkg::SPREAD_W-1:0] min_spread_i,
  input  logic [SB-1:0]                 sample_i,
  input  logic [3*SB-1:0]               entry_i,
  output logic [3*SB-1:0]               entry_o,
  output logic                          ready_set_o,
  output logic                          line_bit_o,
  output logic [SB-1:0]                 threshold_o
);

  localparam int CW = (SB > smcb_pkg::SPREAD_W) ? SB : smcb_pkg::SPREAD_W;

  logic [SB-1:0] lo, hi, thr;
  logic [SB-1:0] lo_n, hi_n, thr_n, mid;
  logic [SB:0]   sum;
  logic [CW-1:0] spread;
  logic          wide_enough;

  always_comb begin
    lo  = entry_i[SB-1:0];
    hi  = entry_i[2*SB-1:SB];
    thr = entry_i[3*SB-1:2*SB];

    lo_n = (sample_i < lo) ? sample_i : lo;
    hi_n = (sample_i > hi) ? sample_i : hi;

    spread      = CW'(hi_n - lo_n);
    wide_enough = (hi_n > lo_n) && (spread > CW'(min_spread_i));

    sum = {1'b0, hi_n} + {1'b0, lo_n};
    mid = sum[SB:1];

    ready_set_o = calibrating_i && wide_enough;
    thr_n       = ready_set_o ? mid : thr;

    // Hold the entry when not calibrating
    entry_o     = calibrating_i ? {thr_n, hi_n, lo_n} : entry_i;
    threshold_o = thr_n;
    line_bit_o  = sample_i > thr_n;
  end

endmodule

// ===== hdl/sensor_minmax_calibrate_binarize.sv =====
// ----------------------------------------------------------------------------
// sensor_minmax_calibrate_binarize
// Per-channel min/max calibration and threshold binarization of sensor samples.
// ----------------------------------------------------------------------------
// Each item carries one converter sample and its channel number and yields one
// result item: the line bit (sample above the channel threshold), the channel
// threshold after the update and a flag that every channel is calibrated.
// While calibrating is set, the lowest and highest sample per channel are
// tracked; once their spread exceeds min_spread the threshold moves to the
// midpoint and the channel is marked ready, a mark that stays set. Items are
// taken one per cycle while results drain: per-channel state lives in a memory
// read at the accept edge and written back at the edge where the item moves on
// to the result register, with the write forwarded to an item on the same
// channel read on that same edge. An item waits in stage 1 during its memory
// read, and a result register lets the next item be taken while a result still
// waits. There is no clearing pass: per-entry valid bits return the reset
// state. Items on channels at or above CHANNELS leave the state alone and
// return zero bit and threshold. The user must write registers (calibrating,
// min_spread) only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module sensor_minmax_calibrate_binarize #(
  parameter int CHANNELS    = smcb_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = smcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  smcb_cfg_if.sink      cfg_i,
  smcb_item_if.sink     item_i,
  smcb_result_if.source result_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHW = smcb_pkg::CHANNEL_W + 2;

  // Entry layout is {threshold, highest, lowest}
  localparam logic [SB-1:0]   LO_RST     = {SB{1'b1}};
  localparam logic [SB-1:0]   HI_RST     = '0;
  localparam logic [SB-1:0]   THR_RST    = SB'(1) << (SB - 1);
  localparam logic [3*SB-1:0] ENTRY_RST  = {THR_RST, HI_RST, LO_RST};
  localparam logic [CHW-1:0]  CH_LIMIT   = CHW'(CHANNELS);

  // Registers
  logic                          calibrating_q;
  logic [smcb_pkg::SPREAD_W-1:0] min_spread_q;

  // Stage 1: item whose memory read is in flight
  logic          s1_vld_q;
  logic          s1_inr_q;
  logic [AW-1:0] s1_addr_q;
  logic [SB-1:0] s1_sample_q;

  // Result register
  logic                       out_vld_q;
  logic                       line_q;
  logic [smcb_pkg::THR_W-1:0] thr_q;
  logic                       allc_q;

  logic [CHANNELS-1:0] ready_q, ready_d;

  logic          accept, advance, s1_fire, in_range;
  logic [AW-1:0] in_addr;
  logic [SB-1:0] in_sample;
  logic          wr_en;

  logic [3*SB-1:0] rd_entry, new_entry;
  logic            ready_set, upd_line;
  logic [SB-1:0]   upd_thr;

  // ------------------------------------------------------------------
  // Register port
  // ------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrating_q <= smcb_pkg::CALIBRATING_RST;
      min_spread_q  <= smcb_pkg::MIN_SPREAD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        smcb_pkg::REG_CALIBRATING: calibrating_q <= cfg_i.data[0];
        smcb_pkg::REG_MIN_SPREAD:  min_spread_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshake: stage 1 moves whenever the result register is free or drains
  // ------------------------------------------------------------------
  assign advance      = !out_vld_q || result_o.ready;
  assign item_i.ready = !s1_vld_q || advance;
  assign accept       = item_i.valid && item_i.ready;
  assign s1_fire      = s1_vld_q && advance;

  assign in_range  = CHW'(item_i.channel) < CH_LIMIT;
  assign in_addr   = AW'(item_i.channel);
  assign in_sample = SB'(item_i.sample);

  // ------------------------------------------------------------------
  // State memory: read on accept, write back as the item leaves stage 1
  // ------------------------------------------------------------------
  assign wr_en = s1_fire && s1_inr_q && calibrating_q;

  smcb_state_mem #(
    .DEPTH      (CHANNELS),
    .AW         (AW),
    .W          (3 * SB),
    .RESET_WORD (ENTRY_RST)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_range),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (new_entry)
  );

  smcb_update #(
    .SB (SB)
  ) u_update (
    .calibrating_i (calibrating_q),
    .min_spread_i  (min_spread_q),
    .sample_i      (s1_sample_q),
    .entry_i       (rd_entry),
    .entry_o       (new_entry),
    .ready_set_o   (ready_set),
    .line_bit_o    (upd_line),
    .threshold_o   (upd_thr)
  );

  // Ready marks only ever set
  always_comb begin
    ready_d = ready_q;
    if (s1_fire && s1_inr_q && ready_set) begin
      ready_d[s1_addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ready_q   <= '0;
    end else begin
      ready_q <= ready_d;
      if (item_i.ready) begin
        s1_vld_q <= item_i.valid;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_inr_q    <= in_range;
      s1_addr_q   <= in_addr;
      s1_sample_q <= in_sample;
    end
  end

  // Result payload; out-of-range channels report zero bit and threshold
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_q <= s1_inr_q && upd_line;
      thr_q  <= s1_inr_q ? smcb_pkg::THR_W'(upd_thr) : '0;
      allc_q <= &ready_d;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.line_bit       = line_q;
  assign result_o.threshold_now  = thr_q;
  assign result_o.all_calibrated = allc_q;

endmodule
